// ----- sv/agkf_pkg.sv -----
`timescale 1ns / 1ps
// agkf_pkg: shared types, constants and helper functions for the angle/gyro-bias kalman filter
// no dependencies

package agkf_pkg;
    localparam int FRAC = 28;
    localparam logic signed [31:0] ONE_Q28 = 32'sh1000_0000;
    localparam logic signed [31:0] MAX32 = 32'sh7fff_ffff;
    localparam logic signed [31:0] MIN32 = 32'sh8000_0000;

    localparam logic [1:0] REG_DT = 2'd0;
    localparam logic [1:0] REG_QA = 2'd1;
    localparam logic [1:0] REG_QB = 2'd2;
    localparam logic [1:0] REG_R  = 2'd3;

    localparam logic [30:0] DT_RST = 31'd1342177;
    localparam logic [30:0] QA_RST = 31'd268435;
    localparam logic [30:0] QB_RST = 31'd805306;
    localparam logic [30:0] R_RST  = 31'd134217728;

    typedef logic signed [31:0] q_t;

    function automatic q_t sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return MAX32;
        if (v < -66'sd2147483648) return MIN32;
        return q_t'(v[31:0]);
    endfunction

    // product scaled by 2^-28, round half up
    function automatic logic signed [65:0] mulq_scale(input logic signed [63:0] p);
        logic signed [65:0] t;
        t = 66'(p) + 66'sd134217728;
        return t >>> FRAC;
    endfunction
endpackage

// ----- sv/angle_gyro_kalman_filter_core.sv -----
`timescale 1ns / 1ps
// angle_gyro_kalman_filter_core: top level, sequencer around one shared multiplier
// depends on agkf_pkg, agkf_div

// Two-state (angle, gyro bias) Kalman filter kept per axis. One transfer in for an axis
// below NUM_AXES gives one transfer out with the filtered angle. The work on an item after
// its input transfer: ten products through a single 33x33 signed multiplier (the product
// registered), five steps of one state each, and two bit-serial divisions of 60 quotient
// bits each for the gains. The result is then presented until taken, and the sequencer
// goes back to idle. When the innovation variance is not positive the divisions and the
// correction are skipped. s_tready is low while an item is worked on or its result waits.
// An axis at or above NUM_AXES is consumed and produces no result. Configuration writes
// are taken at any time and should come idle.
module angle_gyro_kalman_filter_core #(
    parameter int NUM_AXES = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // axis[0], measured_angle[32:1], measured_rate[64:33], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // axis_out[0], filtered_angle[32:1], zero pad
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [30:0] cfg_data
);
    import agkf_pkg::*;

    localparam int AW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

    localparam logic [4:0] S_IDLE = 5'd0,  S_RATE = 5'd1,  S_ANG = 5'd2,  S_T = 5'd3,
                           S_INN = 5'd4,  S_PAA = 5'd5,  S_PBB = 5'd6,  S_DIV0 = 5'd7,
                           S_W0 = 5'd8,   S_DIV1 = 5'd9,  S_W1 = 5'd10, S_ACOR = 5'd11,
                           S_BCOR = 5'd12, S_CAA = 5'd13, S_CAB = 5'd14, S_CBA = 5'd15,
                           S_CBB = 5'd16, S_OUT = 5'd17, S_Y = 5'd18;

    logic [30:0] dt_reg, qa_reg, qb_reg, r_reg;

    q_t ang_reg [NUM_AXES];
    q_t bia_reg [NUM_AXES];
    q_t paa_reg [NUM_AXES];
    q_t pab_reg [NUM_AXES];
    q_t pba_reg [NUM_AXES];
    q_t pbb_reg [NUM_AXES];

    logic [4:0] st_reg, st_next;
    logic [AW-1:0] ax_reg;
    logic       axo_reg;
    q_t ma_reg, mr_reg;
    q_t a_reg, b_reg, caa_reg, cab_reg, cba_reg, cbb_reg;
    q_t t_reg, k0_reg, k1_reg, y_reg, p00_reg, p01_reg, tmp_reg;
    logic [32:0] s_reg;
    logic        phase_reg;          // multiplier issued, result next cycle
    logic        mul_st;
    logic signed [63:0] prod_reg;
    logic signed [32:0] ma_op, mb_op;
    logic       in_ok;

    logic div_start, div_done;
    q_t   div_num, div_q;

    logic signed [65:0] mq;
    assign mq = mulq_scale(prod_reg);

    assign s_tready = (st_reg == S_IDLE);
    assign m_tvalid = (st_reg == S_OUT);
    assign m_tdata = {7'b0, a_reg, axo_reg};
    assign in_ok = 32'(s_tdata[0]) < 32'(NUM_AXES);

    // states that compute one product through the shared multiplier, in an issue and a result phase
    assign mul_st = (st_reg == S_ANG) || (st_reg == S_T) || (st_reg == S_PAA)
                 || (st_reg == S_PBB) || (st_reg == S_ACOR) || (st_reg == S_BCOR)
                 || (st_reg == S_CAA) || (st_reg == S_CAB) || (st_reg == S_CBA)
                 || (st_reg == S_CBB);

    agkf_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .num(div_num),
        .den(s_reg), .done(div_done), .quo(div_q)
    );

    // operand select for the shared multiplier
    always_comb begin
        ma_op = 33'sd0;
        mb_op = 33'sd0;
        unique case (st_reg)
            S_ANG: begin ma_op = {2'b0, dt_reg}; mb_op = 33'(t_reg); end
            S_T:   begin ma_op = {2'b0, dt_reg}; mb_op = 33'(cbb_reg); end
            S_PAA: begin ma_op = {2'b0, dt_reg}; mb_op = 33'(tmp_reg); end
            S_PBB: begin ma_op = {2'b0, qb_reg}; mb_op = {2'b0, dt_reg}; end
            S_ACOR: begin ma_op = 33'(k0_reg); mb_op = 33'(y_reg); end
            S_BCOR: begin ma_op = 33'(k1_reg); mb_op = 33'(y_reg); end
            S_CAA: begin ma_op = 33'(k0_reg); mb_op = 33'(p00_reg); end
            S_CAB: begin ma_op = 33'(k0_reg); mb_op = 33'(p01_reg); end
            S_CBA: begin ma_op = 33'(k1_reg); mb_op = 33'(p00_reg); end
            S_CBB: begin ma_op = 33'(k1_reg); mb_op = 33'(p01_reg); end
            default: ;
        endcase
    end

    assign div_start = (st_reg == S_DIV0) || (st_reg == S_DIV1);
    assign div_num = (st_reg == S_DIV0) ? caa_reg : cba_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= 64'(ma_op) * 64'(mb_op);
        if (!aresetn) begin
            st_reg <= S_IDLE;
            phase_reg <= 1'b0;
            dt_reg <= DT_RST; qa_reg <= QA_RST; qb_reg <= QB_RST; r_reg <= R_RST;
            for (int i = 0; i < NUM_AXES; i++) begin
                ang_reg[i] <= '0; bia_reg[i] <= '0;
                paa_reg[i] <= ONE_Q28; pab_reg[i] <= '0;
                pba_reg[i] <= '0; pbb_reg[i] <= ONE_Q28;
            end
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_DT: dt_reg <= cfg_data;
                    REG_QA: qa_reg <= cfg_data;
                    REG_QB: qb_reg <= cfg_data;
                    REG_R:  r_reg <= cfg_data;
                endcase
            end
            st_reg <= st_next;
            phase_reg <= mul_st && !phase_reg;
            unique case (st_reg)
                S_IDLE: if (s_tvalid && in_ok) begin
                    ax_reg <= AW'(s_tdata[0]);
                    axo_reg <= s_tdata[0];
                    ma_reg <= q_t'(s_tdata[32:1]);
                    mr_reg <= q_t'(s_tdata[64:33]);
                    a_reg <= ang_reg[AW'(s_tdata[0])];
                    b_reg <= bia_reg[AW'(s_tdata[0])];
                    caa_reg <= paa_reg[AW'(s_tdata[0])];
                    cab_reg <= pab_reg[AW'(s_tdata[0])];
                    cba_reg <= pba_reg[AW'(s_tdata[0])];
                    cbb_reg <= pbb_reg[AW'(s_tdata[0])];
                end
                S_RATE: t_reg <= sat32(66'(mr_reg) - 66'(b_reg));
                S_ANG: if (phase_reg) a_reg <= sat32(66'(a_reg) + mq);
                S_T: if (phase_reg) t_reg <= sat32(mq);
                S_INN: begin
                    tmp_reg <= sat32(66'(t_reg) - 66'(cab_reg) - 66'(cba_reg)
                                     + 66'(qa_reg));
                    cab_reg <= sat32(66'(cab_reg) - 66'(t_reg));
                    cba_reg <= sat32(66'(cba_reg) - 66'(t_reg));
                end
                S_PAA: if (phase_reg) caa_reg <= sat32(66'(caa_reg) + mq);
                S_PBB: if (phase_reg) begin
                        cbb_reg <= sat32(66'(cbb_reg) + mq);
                        s_reg <= 33'(caa_reg) + 33'(r_reg);
                     end
                S_Y: y_reg <= sat32(66'(ma_reg) - 66'(a_reg));
                S_DIV0: ;
                S_W0: if (div_done) k0_reg <= div_q;
                S_DIV1: ;
                S_W1: if (div_done) k1_reg <= div_q;
                S_ACOR: if (phase_reg) a_reg <= sat32(66'(a_reg) + mq);
                S_BCOR: if (phase_reg) begin
                        b_reg <= sat32(66'(b_reg) + mq);
                        p00_reg <= caa_reg; p01_reg <= cab_reg;
                     end
                S_CAA: if (phase_reg) caa_reg <= sat32(66'(caa_reg) - mq);
                S_CAB: if (phase_reg) cab_reg <= sat32(66'(cab_reg) - mq);
                S_CBA: if (phase_reg) cba_reg <= sat32(66'(cba_reg) - mq);
                S_CBB: if (phase_reg) cbb_reg <= sat32(66'(cbb_reg) - mq);
                S_OUT: begin
                    ang_reg[ax_reg] <= a_reg; bia_reg[ax_reg] <= b_reg;
                    paa_reg[ax_reg] <= caa_reg; pab_reg[ax_reg] <= cab_reg;
                    pba_reg[ax_reg] <= cba_reg; pbb_reg[ax_reg] <= cbb_reg;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            S_IDLE: if (s_tvalid && in_ok) st_next = S_RATE;
            S_RATE: st_next = S_ANG;
            S_ANG:  if (phase_reg) st_next = S_T;
            S_T:    if (phase_reg) st_next = S_INN;
            S_INN:  st_next = S_PAA;
            S_PAA:  if (phase_reg) st_next = S_PBB;
            S_PBB:  if (phase_reg) st_next = S_Y;
            // nonpositive innovation variance: skip the gains and the correction
            S_Y:    st_next = s_reg[32] || (s_reg == 33'd0) ? S_OUT : S_DIV0;
            S_DIV0: st_next = S_W0;
            S_W0:   if (div_done) st_next = S_DIV1;
            S_DIV1: st_next = S_W1;
            S_W1:   if (div_done) st_next = S_ACOR;
            S_ACOR: if (phase_reg) st_next = S_BCOR;
            S_BCOR: if (phase_reg) st_next = S_CAA;
            S_CAA:  if (phase_reg) st_next = S_CAB;
            S_CAB:  if (phase_reg) st_next = S_CBA;
            S_CBA:  if (phase_reg) st_next = S_CBB;
            S_CBB:  if (phase_reg) st_next = S_OUT;
            S_OUT:  if (m_tready) st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end
endmodule

// ----- sv/agkf_div.sv -----
`timescale 1ns / 1ps
// agkf_div: signed restoring divider, one quotient bit per cycle, saturated to 32 bits
// depends on agkf_pkg

module agkf_div (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  agkf_pkg::q_t         num,      // numerator before scaling by 2^28
    input  logic [32:0]          den,      // positive
    output logic                 done,
    output agkf_pkg::q_t         quo
);
    import agkf_pkg::*;

    logic [59:0] rem_reg, rem_next;     // remaining dividend bits
    logic [59:0] q_reg, q_next;
    logic [32:0] d_reg, d_next;
    logic [33:0] acc_reg, acc_next;
    logic        neg_reg, neg_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [34:0] trial;
    logic [60:0] mag;

    assign trial = {acc_reg, rem_reg[59]} - {2'b0, d_reg};

    always_comb begin
        rem_next = rem_reg;
        q_next = q_reg;
        d_next = d_reg;
        acc_next = acc_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done = 1'b0;
        if (start) begin
            rem_next = {(num[31] ? 32'(-33'(num)) : 32'(num)), 28'b0};
            q_next = '0;
            d_next = den;
            acc_next = '0;
            neg_next = num[31];
            cnt_next = 6'd60;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = {rem_reg[58:0], 1'b0};
            if (!trial[34]) begin
                acc_next = trial[33:0];
                q_next = {q_reg[58:0], 1'b1};
            end else begin
                acc_next = {acc_reg[32:0], rem_reg[59]};
                q_next = {q_reg[58:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done = 1'b1;
            end
        end
    end

    always_comb begin
        mag = {1'b0, q_next};
        if (neg_reg) quo = sat32(-66'(signed'(mag)));
        else quo = sat32(66'(signed'(mag)));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
        rem_reg <= rem_next;
        q_reg <= q_next;
        d_reg <= d_next;
        acc_reg <= acc_next;
        neg_reg <= neg_next;
    end
endmodule
